// ----- src/ece_pkg.sv -----
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Shared constants, curve codes, stage payload types, the quarter-wave sine
// table and the rounding fixed-point multiply.
// ----------------------------------------------------------------------------
package ece_pkg;

  // Number format and table size
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned SINE_ENTRIES  = 256;
  localparam int unsigned Q_W           = FRACTION_BITS + 1;
  localparam int unsigned SINE_ADDR_W   = $clog2(SINE_ENTRIES);
  localparam int unsigned IDX_W         = SINE_ADDR_W + 1;
  localparam int unsigned POS_W         = Q_W + SINE_ADDR_W;
  localparam int unsigned NSTAGE        = 6;

  localparam logic [Q_W-1:0] ONE_Q  = Q_W'(1) << FRACTION_BITS;
  localparam logic [Q_W-1:0] HALF_Q = Q_W'(1) << (FRACTION_BITS - 1);
  localparam logic [63:0]    HALF_PI_Q30 = 64'd1686629713;

  // Curve selector codes
  localparam logic [3:0] MODE_LINEAR       = 4'd0;
  localparam logic [3:0] MODE_SINE_IN      = 4'd1;
  localparam logic [3:0] MODE_SINE_OUT     = 4'd2;
  localparam logic [3:0] MODE_SINE_INOUT   = 4'd3;
  localparam logic [3:0] MODE_QUAD_IN      = 4'd4;
  localparam logic [3:0] MODE_QUAD_OUT     = 4'd5;
  localparam logic [3:0] MODE_QUAD_INOUT   = 4'd6;
  localparam logic [3:0] MODE_CUBIC_IN     = 4'd7;
  localparam logic [3:0] MODE_CUBIC_OUT    = 4'd8;
  localparam logic [3:0] MODE_CUBIC_INOUT  = 4'd9;
  localparam logic [3:0] MODE_QUART_IN     = 4'd10;
  localparam logic [3:0] MODE_QUART_OUT    = 4'd11;
  localparam logic [3:0] MODE_QUART_INOUT  = 4'd12;
  localparam logic [3:0] MODE_QUINT_IN     = 4'd13;
  localparam logic [3:0] MODE_QUINT_OUT    = 4'd14;
  localparam logic [3:0] MODE_QUINT_INOUT  = 4'd15;

  // How the final stage forms the result
  typedef enum logic [2:0] {
    FIN_LINEAR,
    FIN_SINE_IN,
    FIN_SINE_OUT,
    FIN_SINE_INOUT,
    FIN_POW_IN,
    FIN_POW_OUT,
    FIN_POW_INOUT_LO,
    FIN_POW_INOUT_HI
  } fin_e;

  // Payload carried from stage to stage
  typedef struct packed {
    fin_e                     fin;
    logic [2:0]               n;
    logic [Q_W-1:0]           a;
    logic [Q_W-1:0]           r;
    logic [Q_W-1:0]           d;
    logic [FRACTION_BITS-1:0] frac;
  } stage_t;

  // Pipeline control handed to the datapath
  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } ctrl_t;

  typedef logic [Q_W-1:0] sine_rom_t [0:SINE_ENTRIES];

  // sin(x) for x in Q2.30, result in Q30; every term truncated
  function automatic logic [63:0] taylor_sine_f(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Quarter-wave table, entry i holds sin(pi/2 * i / SINE_ENTRIES)
  function automatic sine_rom_t build_sine_rom_f();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] q;
    for (int i = 0; i <= int'(SINE_ENTRIES); i++) begin
      x = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
      s = taylor_sine_f(x);
      q = (s + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
      if (q > 64'(ONE_Q)) begin
        q = 64'(ONE_Q);
      end
      rom[i] = q[Q_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom_f();

  // Fixed-point product, round to nearest with ties up
  function automatic logic [Q_W-1:0] mul_q_f(input logic [Q_W-1:0] a,
                                             input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] prod;
    prod = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(HALF_Q);
    return prod[FRACTION_BITS +: Q_W];
  endfunction

endpackage

// ----- src/ece_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Easing pipeline control
// Valid bits per stage and the ready chain that lets bubbles close up, so a
// stall at the output holds items without loss or repeat.
// ----------------------------------------------------------------------------
module ece_pipe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ece_pkg::ctrl_t ctrl_o
);
  import ece_pkg::*;

  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] valid_d;
  logic [NSTAGE-1:0] ready;
  logic [NSTAGE-1:0] vprev;

  // Build the ready chain from the output backwards
  always_comb begin
    ready[NSTAGE-1] = !valid_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign vprev   = {valid_q[NSTAGE-2:0], in_valid_i};
  assign valid_d = (ready & vprev) | (~ready & valid_q);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load  = ready & vprev;
  assign ctrl_o.valid = valid_q;
  assign in_stall_o   = !ready[0];
  assign out_valid_o  = valid_q[NSTAGE-1];

endmodule

// ----- src/ece_datapath.sv -----
// ----------------------------------------------------------------------------
// Easing datapath
// Six register stages: decode, table read or square, interpolate or cube,
// sine square or fourth power, fifth power, result forming.
// ----------------------------------------------------------------------------
module ece_datapath (
  input  logic                      clk_i,
  input  ece_pkg::ctrl_t            ctrl_i,
  input  logic [3:0]                mode_i,
  input  logic [ece_pkg::Q_W-1:0]   progress_i,
  output logic [ece_pkg::Q_W-1:0]   eased_o
);
  import ece_pkg::*;

  stage_t st_q [0:4];
  stage_t st_d [0:4];
  logic [Q_W-1:0] eased_q;
  logic [Q_W-1:0] eased_d;

  logic [Q_W-1:0] t;
  logic [Q_W-1:0] s;
  logic [Q_W:0]   t2;
  logic [Q_W:0]   s2;

  logic                     is_sine;
  logic [POS_W-1:0]         pos;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_lo;
  logic [IDX_W-1:0]         idx_hi;
  logic [Q_W-1:0]           lo;
  logic [Q_W-1:0]           hi;
  logic [Q_W+FRACTION_BITS-1:0] ip;
  logic [Q_W:0]             half;
  logic [Q_W-1:0]           res;

  // Stage 0: saturate progress, pick operand and curve class
  always_comb begin
    t  = (progress_i > ONE_Q) ? ONE_Q : progress_i;
    s  = ONE_Q - t;
    t2 = {t, 1'b0};
    s2 = {s, 1'b0};
    st_d[0]      = '0;
    st_d[0].fin  = FIN_LINEAR;
    st_d[0].n    = 3'd2;
    st_d[0].a    = t;
    unique case (mode_i)
      MODE_LINEAR: begin
        st_d[0].fin = FIN_LINEAR;
      end
      MODE_SINE_IN: begin
        st_d[0].fin = FIN_SINE_IN;
        st_d[0].a   = s;
      end
      MODE_SINE_OUT: begin
        st_d[0].fin = FIN_SINE_OUT;
      end
      MODE_SINE_INOUT: begin
        st_d[0].fin = FIN_SINE_INOUT;
      end
      MODE_QUAD_IN, MODE_CUBIC_IN, MODE_QUART_IN, MODE_QUINT_IN: begin
        st_d[0].fin = FIN_POW_IN;
      end
      MODE_QUAD_OUT, MODE_CUBIC_OUT, MODE_QUART_OUT, MODE_QUINT_OUT: begin
        st_d[0].fin = FIN_POW_OUT;
        st_d[0].a   = s;
      end
      MODE_QUAD_INOUT, MODE_CUBIC_INOUT, MODE_QUART_INOUT, MODE_QUINT_INOUT: begin
        if (t < HALF_Q) begin
          st_d[0].fin = FIN_POW_INOUT_LO;
          st_d[0].a   = t2[Q_W-1:0];
        end else begin
          st_d[0].fin = FIN_POW_INOUT_HI;
          st_d[0].a   = s2[Q_W-1:0];
        end
      end
      default: begin
        st_d[0].fin = FIN_LINEAR;
      end
    endcase
    // Exponent of the power curves
    unique case (mode_i)
      MODE_CUBIC_IN, MODE_CUBIC_OUT, MODE_CUBIC_INOUT: st_d[0].n = 3'd3;
      MODE_QUART_IN, MODE_QUART_OUT, MODE_QUART_INOUT: st_d[0].n = 3'd4;
      MODE_QUINT_IN, MODE_QUINT_OUT, MODE_QUINT_INOUT: st_d[0].n = 3'd5;
      default:                                         st_d[0].n = 3'd2;
    endcase
  end

  // Stage 1: read table neighbours for sine, square for power curves
  always_comb begin
    is_sine = st_q[0].fin inside {FIN_SINE_IN, FIN_SINE_OUT, FIN_SINE_INOUT};
    pos     = POS_W'(st_q[0].a) * POS_W'(SINE_ENTRIES);
    idx     = pos[POS_W-1:FRACTION_BITS];
    idx_lo  = (idx >= IDX_W'(SINE_ENTRIES)) ? IDX_W'(SINE_ENTRIES) : idx;
    idx_hi  = (idx >= IDX_W'(SINE_ENTRIES)) ? IDX_W'(SINE_ENTRIES) : idx + IDX_W'(1);
    lo      = SINE_ROM[idx_lo];
    hi      = SINE_ROM[idx_hi];
    st_d[1] = st_q[0];
    if (is_sine) begin
      st_d[1].r    = lo;
      st_d[1].d    = (hi >= lo) ? hi - lo : '0;
      st_d[1].frac = pos[FRACTION_BITS-1:0];
    end else begin
      st_d[1].r = mul_q_f(st_q[0].a, st_q[0].a);
    end
  end

  // Stage 2: interpolate sine, cube for power curves
  always_comb begin
    ip = (Q_W+FRACTION_BITS)'(st_q[1].d) * (Q_W+FRACTION_BITS)'(st_q[1].frac)
       + (Q_W+FRACTION_BITS)'(HALF_Q);
    st_d[2] = st_q[1];
    case (st_q[1].fin) inside
      FIN_SINE_IN, FIN_SINE_OUT, FIN_SINE_INOUT: begin
        st_d[2].r = st_q[1].r + ip[FRACTION_BITS +: Q_W];
      end
      FIN_LINEAR: begin
        st_d[2].r = st_q[1].r;
      end
      default: begin
        if (st_q[1].n >= 3'd3) begin
          st_d[2].r = mul_q_f(st_q[1].r, st_q[1].a);
        end
      end
    endcase
  end

  // Stage 3: square sine for in-out, fourth power
  always_comb begin
    st_d[3] = st_q[2];
    case (st_q[2].fin) inside
      FIN_SINE_INOUT: begin
        st_d[3].r = mul_q_f(st_q[2].r, st_q[2].r);
      end
      FIN_POW_IN, FIN_POW_OUT, FIN_POW_INOUT_LO, FIN_POW_INOUT_HI: begin
        if (st_q[2].n >= 3'd4) begin
          st_d[3].r = mul_q_f(st_q[2].r, st_q[2].a);
        end
      end
      default: begin
        st_d[3].r = st_q[2].r;
      end
    endcase
  end

  // Stage 4: fifth power
  always_comb begin
    st_d[4] = st_q[3];
    case (st_q[3].fin) inside
      FIN_POW_IN, FIN_POW_OUT, FIN_POW_INOUT_LO, FIN_POW_INOUT_HI: begin
        if (st_q[3].n >= 3'd5) begin
          st_d[4].r = mul_q_f(st_q[3].r, st_q[3].a);
        end
      end
      default: begin
        st_d[4].r = st_q[3].r;
      end
    endcase
  end

  // Stage 5: form the eased value and clamp
  always_comb begin
    half = ((Q_W+1)'(st_q[4].r) + (Q_W+1)'(1)) >> 1;
    case (st_q[4].fin) inside
      FIN_LINEAR:                             res = st_q[4].a;
      FIN_SINE_IN, FIN_POW_OUT:               res = ONE_Q - st_q[4].r;
      FIN_SINE_OUT, FIN_SINE_INOUT, FIN_POW_IN: res = st_q[4].r;
      FIN_POW_INOUT_LO:                       res = half[Q_W-1:0];
      FIN_POW_INOUT_HI:                       res = ONE_Q - half[Q_W-1:0];
      default:                                res = st_q[4].r;
    endcase
    eased_d = (res > ONE_Q) ? ONE_Q : res;
  end

  // Hold or advance each stage's payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 5; k++) begin
      if (ctrl_i.load[k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (ctrl_i.load[NSTAGE-1]) begin
      eased_q <= eased_d;
    end
  end

  assign eased_o = eased_q;

endmodule

// ----- src/easing_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Evaluates one of sixteen easing curves (linear, sine, quad, cubic, quart,
// quint; in, out and in-out) on a Q1.16 progress value.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-------------------------
//   in       | to block  | in_valid_i / in_stall_o  | mode_i[3:0], progress_i[16:0]
//   out      | from block| out_valid_o / out_stall_i| eased_o[16:0]
//
// One item enters per cycle while in_stall_o is low; each passes six register
// stages before its result is valid. The depth is set by the chain of up
// to four rounding multiplies of the quint curves, one multiplier per
// stage.
// Reset clears the valid bits of all stages; payload registers are not reset.
// A stall at the output holds the last stage; earlier stages keep filling
// until each holds an item, then in_stall_o rises.
//
module easing_curve_evaluator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [3:0]              mode_i,
  input  logic [ece_pkg::Q_W-1:0] progress_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ece_pkg::Q_W-1:0] eased_o
);
  import ece_pkg::*;

  ctrl_t ctrl;

  // Valid and load control
  ece_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // Curve arithmetic
  ece_datapath u_datapath (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .mode_i     (mode_i),
    .progress_i (progress_i),
    .eased_o    (eased_o)
  );

  // An empty output stage means the whole chain can move
  a_accept_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  // An accepted item lands in the first stage
  a_accept_fills_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ctrl.valid[0])
    else $error("accepted item not held in first stage");

  // Results never exceed one
  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (eased_o <= ONE_Q))
    else $error("eased value above one");

endmodule
